// File: rtl/core/isa_dma_channel_registers_assert.svh
// assertion macros for the isa dma channel register block
// used by the port checker; needs nothing else
`ifndef ISA_DMA_CHANNEL_REGISTERS_ASSERT_SVH
`define ISA_DMA_CHANNEL_REGISTERS_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ISADMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isadma: implication failed");

// next-cycle implication, disabled while reset is low
`define ISADMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isadma: next-cycle implication failed");

`endif

// File: rtl/core/isadma_pkg.sv
// shared types, port codes and helpers for the isa dma channel register block
// no dependencies
`timescale 1ns / 1ps

package isadma_pkg;

    localparam int NUM_CH = 4;
    localparam int CH_W   = 2;

    // transaction kinds
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_XFER  = 2'd2
    } t_cmd;

    // i/o port codes
    localparam logic [7:0] PORT_STATUS   = 8'h08;
    localparam logic [7:0] PORT_MASK     = 8'h0A;
    localparam logic [7:0] PORT_MODE     = 8'h0B;
    localparam logic [7:0] PORT_CLEAR_FF = 8'h0C;
    localparam logic [7:0] PORT_PAGE_CH0 = 8'h87;
    localparam logic [7:0] PORT_PAGE_CH1 = 8'h83;
    localparam logic [7:0] PORT_PAGE_CH2 = 8'h81;
    localparam logic [7:0] PORT_PAGE_CH3 = 8'h82;

    // bit positions inside the stored six mode bits
    localparam int MODE_AUTO_BIT = 2;
    localparam int MODE_DEC_BIT  = 3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] port;
        logic [7:0] wdata;
        logic [1:0] channel;
    } t_item;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [23:0] xfer_addr;
        logic        xfer_done;
        logic        terminal_count;
        logic [1:0]  direction;
    } t_result;

    typedef struct packed {
        logic            hit;
        logic [CH_W-1:0] ch;
    } t_page_sel;

    // page register port decode
    function automatic t_page_sel page_lookup(input logic [7:0] port);
        t_page_sel sel;
        sel.hit = 1'b1;
        unique case (port)
            PORT_PAGE_CH0: sel.ch = 2'd0;
            PORT_PAGE_CH1: sel.ch = 2'd1;
            PORT_PAGE_CH2: sel.ch = 2'd2;
            PORT_PAGE_CH3: sel.ch = 2'd3;
            default: begin
                sel.hit = 1'b0;
                sel.ch  = 2'd0;
            end
        endcase
        return sel;
    endfunction

    // byte-pointer steered byte insert and extract
    function automatic logic [15:0] put_byte(input logic [15:0] r, input logic [7:0] b,
                                             input logic hi);
        return hi ? {b, r[7:0]} : {r[15:8], b};
    endfunction

    function automatic logic [7:0] get_byte(input logic [15:0] r, input logic hi);
        return hi ? r[15:8] : r[7:0];
    endfunction

endpackage

// File: rtl/core/isadma_regfile.sv
// channel register file: address, count, page, mode, mask, status, byte pointer
// depends on isadma_pkg
`timescale 1ns / 1ps

module isadma_regfile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  isadma_pkg::t_item   i_item,
    output isadma_pkg::t_result o_result
);
    import isadma_pkg::*;

    logic [15:0] r_base_addr [NUM_CH];
    logic [15:0] r_cur_addr  [NUM_CH];
    logic [15:0] r_base_cnt  [NUM_CH];
    logic [15:0] r_cur_cnt   [NUM_CH];
    logic [7:0]  r_page      [NUM_CH];
    logic [5:0]  r_mode      [NUM_CH];
    logic [3:0]  r_mask;
    logic [3:0]  r_tc;
    logic        r_ptr;

    logic [15:0] n_base_addr [NUM_CH];
    logic [15:0] n_cur_addr  [NUM_CH];
    logic [15:0] n_base_cnt  [NUM_CH];
    logic [15:0] n_cur_cnt   [NUM_CH];
    logic [7:0]  n_page      [NUM_CH];
    logic [5:0]  n_mode      [NUM_CH];
    logic [3:0]  n_mask;
    logic [3:0]  n_tc;
    logic        n_ptr;

    logic            low_port;
    logic [CH_W-1:0] port_ch;
    logic [CH_W-1:0] xch;
    t_page_sel       page_sel;

    assign low_port = (i_item.port[7:3] == 5'd0);
    assign port_ch  = i_item.port[2:1];
    assign xch      = i_item.channel;
    assign page_sel = page_lookup(i_item.port);

    // next state and result for the transaction in the input register
    always_comb begin
        n_base_addr = r_base_addr;
        n_cur_addr  = r_cur_addr;
        n_base_cnt  = r_base_cnt;
        n_cur_cnt   = r_cur_cnt;
        n_page      = r_page;
        n_mode      = r_mode;
        n_mask      = r_mask;
        n_tc        = r_tc;
        n_ptr       = r_ptr;
        o_result    = '0;

        unique case (i_item.cmd)
            CMD_WRITE: begin
                if (low_port) begin
                    if (!i_item.port[0]) begin
                        n_base_addr[port_ch] =
                            put_byte(r_base_addr[port_ch], i_item.wdata, r_ptr);
                        n_cur_addr[port_ch] =
                            put_byte(r_cur_addr[port_ch], i_item.wdata, r_ptr);
                    end else begin
                        n_base_cnt[port_ch] =
                            put_byte(r_base_cnt[port_ch], i_item.wdata, r_ptr);
                        n_cur_cnt[port_ch] =
                            put_byte(r_cur_cnt[port_ch], i_item.wdata, r_ptr);
                    end
                    n_ptr = ~r_ptr;
                end else if (i_item.port == PORT_MASK) begin
                    n_mask[i_item.wdata[1:0]] = i_item.wdata[2];
                end else if (i_item.port == PORT_MODE) begin
                    n_mode[i_item.wdata[1:0]] = i_item.wdata[7:2];
                end else if (i_item.port == PORT_CLEAR_FF) begin
                    n_ptr = 1'b0;
                end else if (page_sel.hit) begin
                    n_page[page_sel.ch] = i_item.wdata;
                end
            end
            CMD_READ: begin
                if (low_port) begin
                    o_result.rdata = i_item.port[0] ? get_byte(r_cur_cnt[port_ch], r_ptr)
                                                    : get_byte(r_cur_addr[port_ch], r_ptr);
                    n_ptr = ~r_ptr;
                end else if (i_item.port == PORT_STATUS) begin
                    // request bits read as zero, terminal counts clear on read
                    o_result.rdata = {4'd0, r_tc};
                    n_tc = '0;
                end
            end
            CMD_XFER: begin
                o_result.direction = r_mode[xch][1:0];
                if (!r_mask[xch]) begin
                    o_result.xfer_done = 1'b1;
                    o_result.xfer_addr = {r_page[xch], r_cur_addr[xch]};
                    n_cur_addr[xch] = r_mode[xch][MODE_DEC_BIT] ? r_cur_addr[xch] - 16'd1
                                                                : r_cur_addr[xch] + 16'd1;
                    if (r_cur_cnt[xch] == 16'd0) begin
                        // count wrap: reload in auto-init, else mask the channel
                        o_result.terminal_count = 1'b1;
                        n_tc[xch] = 1'b1;
                        if (r_mode[xch][MODE_AUTO_BIT]) begin
                            n_cur_addr[xch] = r_base_addr[xch];
                            n_cur_cnt[xch]  = r_base_cnt[xch];
                        end else begin
                            n_cur_cnt[xch] = 16'hFFFF;
                            n_mask[xch]    = 1'b1;
                        end
                    end else begin
                        n_cur_cnt[xch] = r_cur_cnt[xch] - 16'd1;
                    end
                end
            end
            default: begin
                // unused command code: no effect
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_base_addr[i] <= '0;
                r_cur_addr[i]  <= '0;
                r_base_cnt[i]  <= '0;
                r_cur_cnt[i]   <= '0;
                r_page[i]      <= '0;
                r_mode[i]      <= '0;
            end
            r_mask <= '1;
            r_tc   <= '0;
            r_ptr  <= 1'b0;
        end else if (i_en) begin
            r_base_addr <= n_base_addr;
            r_cur_addr  <= n_cur_addr;
            r_base_cnt  <= n_base_cnt;
            r_cur_cnt   <= n_cur_cnt;
            r_page      <= n_page;
            r_mode      <= n_mode;
            r_mask      <= n_mask;
            r_tc        <= n_tc;
            r_ptr       <= n_ptr;
        end
    end

endmodule

// File: rtl/core/isa_dma_channel_registers.sv
// top level of the isa dma channel register block: input register, register file,
// result register; depends on isadma_pkg and isadma_regfile
`timescale 1ns / 1ps

// Usage
//   input channel : i_valid / o_ready with i_cmd, i_port, i_wdata, i_channel.
//     a transaction is a bus write, a bus read or one transfer cycle.
//   output channel: o_valid / i_ready with o_rdata, o_xfer_addr, o_xfer_done,
//     o_terminal_count, o_direction; exactly one result per transaction, in order.
// Path: an accepted transaction is held in the input register; when the result
//   register is free or draining, the register file updates and the result
//   register captures the result together, raising o_valid.
// Throughput: one transaction per cycle while i_ready holds; the register file does each
//   read-modify-write combinationally ahead of its state registers.
// Reset (i_rst_n low, synchronous): both stages empty, address/count/page/mode
//   and status cleared, all four channels masked, byte pointer on the low byte.
// Stall: while i_ready is low the result register holds; the input register can
//   still take one more transaction, after which o_ready drops until the
//   receiver takes the waiting result.
module isa_dma_channel_registers (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_port,
    input  logic [7:0]  i_wdata,
    input  logic [1:0]  i_channel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_rdata,
    output logic [23:0] o_xfer_addr,
    output logic        o_xfer_done,
    output logic        o_terminal_count,
    output logic [1:0]  o_direction
);
    import isadma_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    advance;

    // move the held transaction on when the result register is free or draining
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    isadma_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= '{cmd: i_cmd, port: i_port, wdata: i_wdata, channel: i_channel};
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_rdata          = r_out.rdata;
    assign o_xfer_addr      = r_out.xfer_addr;
    assign o_xfer_done      = r_out.xfer_done;
    assign o_terminal_count = r_out.terminal_count;
    assign o_direction      = r_out.direction;

endmodule

// File: rtl/core/isadma_checker.sv
// port-level checks for the isa dma channel register block, bound to the top level
// depends on isa_dma_channel_registers_assert.svh
`timescale 1ns / 1ps

module isadma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_rdata,
    input logic [23:0] o_xfer_addr,
    input logic        o_xfer_done,
    input logic        o_terminal_count,
    input logic [1:0]  o_direction
);
`include "isa_dma_channel_registers_assert.svh"

    // a stalled result stays put
    `ISADMA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_rdata) && $stable(o_xfer_addr))

    // output register comes out of reset empty
    `ISADMA_ASSERT_IMPLY(a_empty_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_valid)

    // terminal count only on a transfer that ran
    `ISADMA_ASSERT_IMPLY(a_tc_needs_xfer, i_clk, i_rst_n, o_valid && o_terminal_count, o_xfer_done)

    // no transfer, no address; read data and transfer fields never mix
    `ISADMA_ASSERT_IMPLY(a_idle_addr_zero, i_clk, i_rst_n, o_valid && !o_xfer_done, o_xfer_addr == 24'd0)
    `ISADMA_ASSERT_IMPLY(a_read_excl, i_clk, i_rst_n, o_valid && (o_rdata != 8'd0), !o_xfer_done && (o_direction == 2'd0))

endmodule

bind isa_dma_channel_registers isadma_checker u_isadma_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_rdata          (o_rdata),
    .o_xfer_addr      (o_xfer_addr),
    .o_xfer_done      (o_xfer_done),
    .o_terminal_count (o_terminal_count),
    .o_direction      (o_direction)
);
